>>> rtl/assert_macros.svh
// Assertion helpers, clocked on clk and disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent holds in the same cycle.
`define CCC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("concentric check: same-cycle assertion failed");

// Consequent holds in the next cycle.
`define CCC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("concentric check: next-cycle assertion failed");

`endif

>>> rtl/ccc_pkg.sv
package ccc_pkg;

	localparam int COORD_W = 16;
	localparam int THR_W   = 17;
	localparam int ROI_W   = 12;
	localparam int MEAN_W  = 13;
	localparam int DEV_W   = 17;
	localparam int SQ_W    = 32;
	localparam int RAD_W   = 34;
	localparam int ROOT_W  = 17;
	localparam int STAT_W  = 2;
	localparam int CFG_IDX_W = 2;

	localparam logic [STAT_W-1:0] ST_CONCENTRIC     = 2'd0;
	localparam logic [STAT_W-1:0] ST_NO_CIRCLES     = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOT_CONCENTRIC = 2'd2;
	localparam logic [STAT_W-1:0] ST_TOO_MANY       = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROI_X     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROI_Y     = 2'd2;

	typedef enum logic [1:0] {
		DIV_X,
		DIV_Y,
		DIV_DEV
	} div_sel_t;

	typedef struct packed {
		logic     load;
		logic     div_start;
		div_sel_t div_sel;
		logic     lat_mx;
		logic     lat_my;
		logic     lat_dev;
		logic     idx_clr;
		logic     idx_inc;
		logic     rd;
		logic     diff;
		logic     sqx;
		logic     sqy;
		logic     sqrt_start;
		logic     acc;
		logic     emit;
	} ccc_cmd_t;

	typedef struct packed {
		logic count_zero;
		logic idx_last;
		logic div_done;
		logic sqrt_done;
		logic out_free;
	} ccc_sts_t;

endpackage

>>> rtl/ccc_ram.sv
module ccc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/ccc_div.sv
module ccc_div #(
	parameter int NW = 26,
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);

	localparam int CNT_W = $clog2(NW + 1);

	logic [NW-1:0]    num_q;
	logic [DW-1:0]    den_q;
	logic [DW-1:0]    rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DW:0]      sh;
	logic             qbit;

	assign sh   = {rem_q, num_q[NW-1]};
	assign qbit = (sh >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= qbit ? DW'(sh - {1'b0, den_q}) : DW'(sh);
			num_q <= {num_q[NW-2:0], qbit};
		end
	end

	assign done = done_q;
	assign quo  = num_q;

endmodule

>>> rtl/ccc_sqrt.sv
module ccc_sqrt
	import ccc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [RAD_W-1:0]  radicand,
	output logic              done,
	output logic [ROOT_W-1:0] root
);

	localparam int CNT_W = $clog2(ROOT_W + 1);
	localparam int REM_W = ROOT_W + 2;

	logic [RAD_W-1:0]  v_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [REM_W+1:0]  sh;
	logic [REM_W+1:0]  trial;
	logic              take;

	assign sh    = {rem_q, v_q[RAD_W-1 -: 2]};
	assign trial = (REM_W+2)'({root_q, 2'b01});
	assign take  = (sh >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			v_q    <= {v_q[RAD_W-3:0], 2'b00};
			rem_q  <= take ? REM_W'(sh - trial) : REM_W'(sh);
			root_q <= {root_q[ROOT_W-2:0], take};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

>>> rtl/ccc_datapath.sv
module ccc_datapath #(
	parameter int MAX_CENTERS = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ccc_pkg::ccc_cmd_t                 cmd,
	output ccc_pkg::ccc_sts_t                 sts,
	input  logic                              cfg_valid,
	input  logic [ccc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ccc_pkg::THR_W-1:0]         cfg_data,
	input  logic [ccc_pkg::COORD_W-1:0]       center_x,
	input  logic [ccc_pkg::COORD_W-1:0]       center_y,
	input  logic                              has_center,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [ccc_pkg::STAT_W-1:0]        status,
	output logic                              concentric,
	output logic [ccc_pkg::MEAN_W-1:0]        mean_x,
	output logic [ccc_pkg::MEAN_W-1:0]        mean_y,
	output logic [ccc_pkg::DEV_W-1:0]         deviation
);

	import ccc_pkg::*;

	localparam int AW  = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
	localparam int CW  = $clog2(MAX_CENTERS + 1);
	localparam int SW  = COORD_W + CW;
	localparam int DSW = ROOT_W + CW;
	localparam int NW  = DSW + 2;
	localparam int DNW = CW + 1;

	logic [THR_W-1:0]   thr_q;
	logic [ROI_W-1:0]   roi_x_q;
	logic [ROI_W-1:0]   roi_y_q;
	logic [CW-1:0]      count_q;
	logic [SW-1:0]      sum_x_q;
	logic [SW-1:0]      sum_y_q;
	logic               ovf_q;
	logic [AW-1:0]      idx_q;
	logic [COORD_W-1:0] mx_q;
	logic [COORD_W-1:0] my_q;
	logic [DEV_W-1:0]   dev_q;
	logic [DSW-1:0]     dsum_q;
	logic [COORD_W-1:0] dx_q;
	logic [COORD_W-1:0] dy_q;
	logic [SQ_W-1:0]    sqx_q;
	logic [SQ_W-1:0]    sqy_q;
	logic               out_valid_q;
	logic               full;
	logic               store;
	logic [COORD_W-1:0] rdx;
	logic [COORD_W-1:0] rdy;
	logic [NW-1:0]      div_num;
	logic [NW-1:0]      div_arg;
	logic [DNW-1:0]     div_den;
	logic               div_done;
	logic [NW-1:0]      quo;
	logic               sqrt_done;
	logic [ROOT_W-1:0]  root;
	logic               conc;

	assign full  = (count_q == CW'(MAX_CENTERS));
	assign store = cmd.load && has_center && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= THR_W'(32);
			roi_x_q <= '0;
			roi_y_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_THRESHOLD: thr_q   <= cfg_data;
				CFG_ROI_X:     roi_x_q <= cfg_data[ROI_W-1:0];
				CFG_ROI_Y:     roi_y_q <= cfg_data[ROI_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_x_q <= '0;
			sum_y_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.emit) begin
			count_q <= '0;
			sum_x_q <= '0;
			sum_y_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.load && has_center) begin
			if (full) begin
				ovf_q <= 1'b1;
			end else begin
				count_q <= count_q + CW'(1);
				sum_x_q <= sum_x_q + SW'(center_x);
				sum_y_q <= sum_y_q + SW'(center_y);
			end
		end
	end

	ccc_ram #(.WIDTH(COORD_W), .DEPTH(MAX_CENTERS)) u_ram_x (
		.clk   (clk),
		.we    (store),
		.waddr (count_q[AW-1:0]),
		.wdata (center_x),
		.re    (cmd.rd),
		.raddr (idx_q),
		.rdata (rdx)
	);

	ccc_ram #(.WIDTH(COORD_W), .DEPTH(MAX_CENTERS)) u_ram_y (
		.clk   (clk),
		.we    (store),
		.waddr (count_q[AW-1:0]),
		.wdata (center_y),
		.re    (cmd.rd),
		.raddr (idx_q),
		.rdata (rdy)
	);

	always_comb begin
		case (cmd.div_sel)
			DIV_X:   div_num = NW'(sum_x_q);
			DIV_Y:   div_num = NW'(sum_y_q);
			DIV_DEV: div_num = NW'(dsum_q);
			default: div_num = '0;
		endcase
		div_arg = NW'({div_num, 1'b0}) + NW'(count_q);
		div_den = {count_q, 1'b0};
	end

	ccc_div #(.NW(NW), .DW(DNW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_arg),
		.den    (div_den),
		.done   (div_done),
		.quo    (quo)
	);

	ccc_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sqrt_start),
		.radicand (RAD_W'(sqx_q) + RAD_W'(sqy_q)),
		.done     (sqrt_done),
		.root     (root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lat_mx) begin
			mx_q <= quo[COORD_W-1:0];
		end
		if (cmd.lat_my) begin
			my_q <= quo[COORD_W-1:0];
		end
		if (cmd.lat_dev) begin
			dev_q <= quo[DEV_W-1:0];
		end
		if (cmd.idx_clr) begin
			dsum_q <= '0;
		end else if (cmd.acc) begin
			dsum_q <= dsum_q + DSW'(root);
		end
		if (cmd.diff) begin
			dx_q <= (rdx >= mx_q) ? rdx - mx_q : mx_q - rdx;
			dy_q <= (rdy >= my_q) ? rdy - my_q : my_q - rdy;
		end
		if (cmd.sqx) begin
			sqx_q <= dx_q * dx_q;
		end
		if (cmd.sqy) begin
			sqy_q <= dy_q * dy_q;
		end
	end

	assign conc = (dev_q <= thr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			if (count_q == '0) begin
				status     <= ST_NO_CIRCLES;
				concentric <= 1'b0;
				mean_x     <= '0;
				mean_y     <= '0;
				deviation  <= '0;
			end else begin
				status     <= ovf_q ? ST_TOO_MANY : (conc ? ST_CONCENTRIC : ST_NOT_CONCENTRIC);
				concentric <= conc;
				mean_x     <= MEAN_W'((17'(mx_q) + 17'd8) >> 4) + MEAN_W'(roi_x_q);
				mean_y     <= MEAN_W'((17'(my_q) + 17'd8) >> 4) + MEAN_W'(roi_y_q);
				deviation  <= dev_q;
			end
		end
	end

	assign out_valid = out_valid_q;

	assign sts.count_zero = (count_q == '0);
	assign sts.idx_last   = (CW'(idx_q) + CW'(1) == count_q);
	assign sts.div_done   = div_done;
	assign sts.sqrt_done  = sqrt_done;
	assign sts.out_free   = !out_valid_q || !out_stall;

endmodule

>>> rtl/ccc_ctrl.sv
module ccc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              last_center,
	output logic              in_stall,
	output ccc_pkg::ccc_cmd_t cmd,
	input  ccc_pkg::ccc_sts_t sts
);

	import ccc_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHK,
		S_DIVX,
		S_DIVY,
		S_RD,
		S_DIFF,
		S_SQX,
		S_SQY,
		S_SQS,
		S_SQW,
		S_DEVS,
		S_DEVW,
		S_EMIT
	} state_t;

	state_t state_q;
	logic   stall_q;
	logic   accept;

	assign accept = (state_q == S_IDLE) && in_valid && !stall_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stall_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept && last_center) begin
						state_q <= S_CHK;
						stall_q <= 1'b1;
					end
				end
				S_CHK:  state_q <= sts.count_zero ? S_EMIT : S_DIVX;
				S_DIVX: if (sts.div_done) state_q <= S_DIVY;
				S_DIVY: if (sts.div_done) state_q <= S_RD;
				S_RD:   state_q <= S_DIFF;
				S_DIFF: state_q <= S_SQX;
				S_SQX:  state_q <= S_SQY;
				S_SQY:  state_q <= S_SQS;
				S_SQS:  state_q <= S_SQW;
				S_SQW: begin
					if (sts.sqrt_done) begin
						state_q <= sts.idx_last ? S_DEVS : S_RD;
					end
				end
				S_DEVS: state_q <= S_DEVW;
				S_DEVW: if (sts.div_done) state_q <= S_EMIT;
				S_EMIT: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
						stall_q <= 1'b0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd         = '0;
		cmd.div_sel = DIV_X;
		cmd.load    = accept;
		unique case (state_q)
			S_CHK: begin
				cmd.div_start = !sts.count_zero;
			end
			S_DIVX: begin
				cmd.lat_mx    = sts.div_done;
				cmd.div_start = sts.div_done;
				cmd.div_sel   = DIV_Y;
			end
			S_DIVY: begin
				cmd.lat_my  = sts.div_done;
				cmd.idx_clr = sts.div_done;
			end
			S_RD:   cmd.rd = 1'b1;
			S_DIFF: cmd.diff = 1'b1;
			S_SQX:  cmd.sqx = 1'b1;
			S_SQY:  cmd.sqy = 1'b1;
			S_SQS:  cmd.sqrt_start = 1'b1;
			S_SQW: begin
				cmd.acc     = sts.sqrt_done;
				cmd.idx_inc = sts.sqrt_done && !sts.idx_last;
			end
			S_DEVS: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_DEV;
			end
			S_DEVW: cmd.lat_dev = sts.div_done;
			S_EMIT: cmd.emit = sts.out_free;
			default: ;
		endcase
	end

	assign in_stall = stall_q;

endmodule

>>> rtl/concentric_center_check.sv
// Concentric center check.
// Input channel (in_valid / in_stall): one item per center, fields center_x,
// center_y (unsigned Q12.4), has_center and last_center. An item with
// last_center set closes the set; its own center joins first.
// Output channel (out_valid / out_stall): one result per closed set with
// status, concentric, mean_x, mean_y and deviation.
// Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data): index 0 is the
// threshold, 1 and 2 the region origin; cfg_ready is always high.
// Loading items are taken while in_stall is low. After the closing item, the
// evaluation runs the bit-serial divider for three divisions (mean x, mean y,
// deviation), NW = 19 + clog2(MAX_CENTERS + 1) bits wide (26 at the default depth),
// and the 17-step square root per stored center; an empty set skips both.
// in_stall stays high for the whole evaluation.
// Reset clears the set, holds the threshold at 2.0 pixels and the origin at 0.
// A stalled result holds in the output register; the block waits for it to
// drain before it loads the next result and takes new items.
module concentric_center_check #(
	parameter int MAX_CENTERS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [ccc_pkg::COORD_W-1:0]   center_x,
	input  logic [ccc_pkg::COORD_W-1:0]   center_y,
	input  logic                          has_center,
	input  logic                          last_center,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ccc_pkg::STAT_W-1:0]    status,
	output logic                          concentric,
	output logic [ccc_pkg::MEAN_W-1:0]    mean_x,
	output logic [ccc_pkg::MEAN_W-1:0]    mean_y,
	output logic [ccc_pkg::DEV_W-1:0]     deviation,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ccc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ccc_pkg::THR_W-1:0]     cfg_data
);

	import ccc_pkg::*;

	ccc_cmd_t cmd;
	ccc_sts_t sts;

	assign cfg_ready = 1'b1;

	ccc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.last_center (last_center),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.sts         (sts)
	);

	ccc_datapath #(.MAX_CENTERS(MAX_CENTERS)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.center_x   (center_x),
		.center_y   (center_y),
		.has_center (has_center),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.concentric (concentric),
		.mean_x     (mean_x),
		.mean_y     (mean_y),
		.deviation  (deviation)
	);

endmodule

>>> rtl/ccc_checker.sv
`include "assert_macros.svh"

module ccc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          last_center,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [ccc_pkg::STAT_W-1:0]    status,
	input logic                          concentric,
	input logic [ccc_pkg::MEAN_W-1:0]    mean_x,
	input logic [ccc_pkg::MEAN_W-1:0]    mean_y,
	input logic [ccc_pkg::DEV_W-1:0]     deviation
);

	import ccc_pkg::*;

	`CCC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	`CCC_ASSERT_NEXT(a_busy_after_last, in_valid && !in_stall && last_center, in_stall)
	`CCC_ASSERT_NOW(a_empty_zero, out_valid && status == ST_NO_CIRCLES, !concentric && deviation == '0 && mean_x == '0 && mean_y == '0)
	`CCC_ASSERT_NOW(a_flag_match, out_valid && (status == ST_CONCENTRIC || status == ST_NOT_CONCENTRIC), concentric == (status == ST_CONCENTRIC))

endmodule

bind concentric_center_check ccc_checker u_ccc_checker (.*);

>>> dv/concentric_center_check_tb.sv
`timescale 1ns / 1ps

module concentric_center_check_tb;
	import ccc_pkg::*;

	localparam int DEPTH = 64;
	localparam int IDLE_LIMIT = 20000;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic concentric;
		logic [MEAN_W-1:0] mean_x;
		logic [MEAN_W-1:0] mean_y;
		logic [DEV_W-1:0] deviation;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [COORD_W-1:0] center_x = '0;
	logic [COORD_W-1:0] center_y = '0;
	logic has_center = 1'b0;
	logic last_center = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [STAT_W-1:0] status;
	logic concentric;
	logic [MEAN_W-1:0] mean_x;
	logic [MEAN_W-1:0] mean_y;
	logic [DEV_W-1:0] deviation;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [THR_W-1:0] cfg_data = '0;

	logic [COORD_W-1:0] set_x[DEPTH];
	logic [COORD_W-1:0] set_y[DEPTH];
	int unsigned set_count;
	logic [23:0] sum_x, sum_y;
	bit set_overflow;
	logic [THR_W-1:0] dev_limit;
	logic [ROI_W-1:0] roi_x, roi_y;

	verdict_t pending_verdicts[$];
	int errors;
	int idle_cycles;
	int out_wait;
	bit long_hold;

	concentric_center_check DUT (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic longint unsigned isqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned div_round(longint unsigned n, longint unsigned d);
		return (2 * n + d) / (2 * d);
	endfunction

	function automatic void clear_set();
		set_count = 0;
		sum_x = 0;
		sum_y = 0;
		set_overflow = 0;
	endfunction

	function automatic void predict_center(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
			bit has, bit last);
		verdict_t v;
		longint unsigned mx, my, dx, dy, acc, dev;
		v = '0;
		if (has) begin
			if (set_count < DEPTH) begin
				set_x[set_count] = x;
				set_y[set_count] = y;
				sum_x += x;
				sum_y += y;
				set_count++;
			end else begin
				set_overflow = 1;
			end
		end
		if (!last) return;
		if (set_count == 0) begin
			v.status = ST_NO_CIRCLES;
		end else begin
			mx = div_round(sum_x, set_count);
			my = div_round(sum_y, set_count);
			acc = 0;
			for (int i = 0; i < set_count; i++) begin
				dx = set_x[i] >= mx ? set_x[i] - mx : mx - set_x[i];
				dy = set_y[i] >= my ? set_y[i] - my : my - set_y[i];
				acc += isqrt(dx * dx + dy * dy);
			end
			dev = div_round(acc, set_count) & 17'h1FFFF;
			v.concentric = (dev <= dev_limit);
			if (set_overflow) v.status = ST_TOO_MANY;
			else v.status = v.concentric ? ST_CONCENTRIC : ST_NOT_CONCENTRIC;
			v.mean_x = MEAN_W'(((mx + 8) >> 4) + roi_x);
			v.mean_y = MEAN_W'(((my + 8) >> 4) + roi_y);
			v.deviation = DEV_W'(dev);
		end
		pending_verdicts.insert(pending_verdicts.size(), v);
		clear_set();
	endfunction

	task automatic send_center(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, bit has,
			bit last);
		int gap;
		gap = $urandom_range(0, 3);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		center_x <= x;
		center_y <= y;
		has_center <= has;
		last_center <= last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_center(x, y, has, last);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [THR_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_THRESHOLD: dev_limit = val;
			CFG_ROI_X: roi_x = val[ROI_W-1:0];
			CFG_ROI_Y: roi_y = val[ROI_W-1:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (3000) @(posedge clk);
	endtask

	task automatic send_set(int n, int spread);
		logic [COORD_W-1:0] bx, by;
		bx = COORD_W'($urandom);
		by = COORD_W'($urandom);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_center(COORD_W'($urandom), COORD_W'($urandom), 1'b0, 1'b0);
			send_center(spread == 0 ? COORD_W'($urandom) :
					COORD_W'(bx + $urandom_range(0, spread)),
				spread == 0 ? COORD_W'($urandom) :
					COORD_W'(by + $urandom_range(0, spread)), 1'b1, i == n - 1);
		end
	endtask

	task automatic test_directed();
		send_center('0, '0, 1'b0, 1'b1);
		send_center('0, '0, 1'b1, 1'b1);
		send_center('1, '1, 1'b1, 1'b1);
		send_center('1, '1, 1'b1, 1'b0);
		send_center('0, '0, 1'b1, 1'b1);
		send_center(16'd8, 16'd8, 1'b1, 1'b0);
		send_center(16'd9, 16'd9, 1'b1, 1'b0);
		send_center(16'd0, 16'd0, 1'b0, 1'b1);
		send_center(16'h5555, 16'hAAAA, 1'b1, 1'b0);
		send_center(16'hAAAA, 16'h5555, 1'b1, 1'b1);
		send_center(16'd100, 16'd100, 1'b1, 1'b0);
		send_center(16'd131, 16'd100, 1'b1, 1'b1);
		drain();
	endtask

	task automatic test_overflow();
		for (int i = 0; i < DEPTH + 3; i++)
			send_center(COORD_W'($urandom), COORD_W'($urandom), 1'b1, i == DEPTH + 2);
		for (int i = 0; i < DEPTH; i++)
			send_center(COORD_W'(16'd1000 + $urandom_range(0, 40)), 16'd2000, 1'b1,
				i == DEPTH - 1);
		drain();
	endtask

	task automatic test_config(logic [THR_W-1:0] thr, logic [ROI_W-1:0] ox, logic [ROI_W-1:0] oy,
			int sets);
		write_reg(CFG_THRESHOLD, thr);
		write_reg(CFG_ROI_X, THR_W'(ox));
		write_reg(CFG_ROI_Y, THR_W'(oy));
		cfg_valid <= 1'b0;
		for (int s = 0; s < sets; s++) begin
			case ($urandom_range(0, 3))
				0: send_set($urandom_range(1, 4), 0);
				1: send_set($urandom_range(1, 8), $urandom_range(0, 80));
				2: send_center(COORD_W'($urandom), COORD_W'($urandom), 1'b0, 1'b1);
				default: send_set($urandom_range(2, 12), $urandom_range(0, 16));
			endcase
		end
		drain();
	endtask

	task automatic test_backpressure();
		long_hold = 1;
		for (int s = 0; s < 6; s++) send_set(3, 20);
		drain();
		wait (!long_hold);
	endtask

	initial begin
		long_hold = 0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (2500) @(posedge clk);
				out_stall <= 1'b0;
				long_hold = 0;
			end else if (out_valid && !out_stall) begin
				out_wait = $urandom_range(0, 3);
				if (out_wait != 0) begin
					out_stall <= 1'b1;
					repeat (out_wait) @(posedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		verdict_t v;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_verdicts.size() == 0) begin
				errors++;
				$display("%0t: result with none expected, actual %h", $time,
					{status, concentric, mean_x, mean_y, deviation});
			end else begin
				v = pending_verdicts.pop_front();
				if (v != {status, concentric, mean_x, mean_y, deviation}) begin
					errors++;
					$display("%0t: status exp %0d act %0d", $time, v.status, status);
					$display("%0t: concentric exp %0d act %0d", $time, v.concentric, concentric);
					$display("%0t: mean_x exp %0d act %0d", $time, v.mean_x, mean_x);
					$display("%0t: mean_y exp %0d act %0d", $time, v.mean_y, mean_y);
					$display("%0t: deviation exp %0d act %0d", $time, v.deviation, deviation);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		errors = 0;
		idle_cycles = 0;
		dev_limit = 32;
		roi_x = 0;
		roi_y = 0;
		clear_set();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_overflow();
		test_config('0, '1, '1, 15);
		test_config('1, '0, '0, 15);
		test_config(17'd40, 12'd300, 12'd4000, 25);
		test_config(THR_W'($urandom), ROI_W'($urandom), ROI_W'($urandom), 25);
		test_backpressure();
		test_config(17'd32, 12'd0, 12'd0, 30);
		if (errors == 0 && pending_verdicts.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl
rtl/ccc_pkg.sv
rtl/ccc_ram.sv
rtl/ccc_div.sv
rtl/ccc_sqrt.sv
rtl/ccc_datapath.sv
rtl/ccc_ctrl.sv
rtl/concentric_center_check.sv
rtl/ccc_checker.sv
dv/concentric_center_check_tb.sv
